// ===== rtl/ed565_pkg.sv =====
// ----------------------------------------------------------------------------
// ed565_pkg
// Shared constants, types and channel arithmetic for the RGB565 error
// diffusion unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ed565_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int CNT_W      = COL_W + 1;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 3;
    localparam int ERR_W      = 8;
    localparam int DIFF_W     = 5;

    localparam int CH_RED     = 0;
    localparam int CH_GREEN   = 1;
    localparam int CH_BLUE    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [NUM_CH-1:0] pix_vec_t;

    // Two's complement error in sixteenths of a code step.
    typedef logic [ERR_W-1:0] err_t;
    typedef err_t [NUM_CH-1:0] err_vec_t;

    typedef logic [DIFF_W-1:0] diff_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             last_col;
        logic             last_row;
    } pos_t;

    typedef struct packed {
        pix_t  value;
        diff_t diff;
    } chan_res_t;

    function automatic err_t ext_diff(input diff_t d);
        return {{(ERR_W-DIFF_W){d[DIFF_W-1]}}, d};
    endfunction

    function automatic chan_res_t dither_chan(input pix_t pix, input err_t cur,
                                              input err_t carry, input logic six_bits);
        logic [ERR_W:0]   e16;
        logic             adj;
        logic [4:0]       q;
        logic [9:0]       sum;
        pix_t             clamped;
        pix_t             outv;
        logic [PIX_W:0]   diff_full;
        chan_res_t        res;
        e16 = {cur[ERR_W-1], cur} + {carry[ERR_W-1], carry};
        // Division by sixteen rounds toward zero, so negative values with a
        // fractional part move up by one.
        adj = e16[ERR_W] & (|e16[3:0]);
        q = e16[ERR_W:4] + {4'b0000, adj};
        sum = {2'b00, pix} + {{5{q[4]}}, q};
        if (sum[9]) begin
            clamped = '0;
        end else if (sum[8]) begin
            clamped = '1;
        end else begin
            clamped = sum[7:0];
        end
        if (six_bits) begin
            outv = {clamped[7:2], clamped[7:6]};
        end else begin
            outv = {clamped[7:3], clamped[7:5]};
        end
        diff_full = {1'b0, clamped} - {1'b0, outv};
        res.value = outv;
        res.diff = diff_full[DIFF_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ed565_row_mem.sv =====
// ----------------------------------------------------------------------------
// ed565_row_mem
// Single-port-write, single-port-read row error memory with registered,
// write-first read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ed565_row_mem (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [ed565_pkg::COL_W-1:0] wr_addr,
    input  wire ed565_pkg::err_vec_t        wr_data,
    input  wire logic                       rd_en,
    input  wire logic [ed565_pkg::COL_W-1:0] rd_addr,
    output ed565_pkg::err_vec_t             rd_data
);

    ed565_pkg::err_vec_t mem_reg [ed565_pkg::MAX_WIDTH];
    ed565_pkg::err_vec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/ed565_position.sv =====
// ----------------------------------------------------------------------------
// ed565_position
// Image geometry registers and the raster position of the next transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ed565_position (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ed565_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ed565_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                           advance,
    output ed565_pkg::pos_t                     pos
);

    logic [ed565_pkg::WIDTH_W-1:0]  width_reg;
    logic [ed565_pkg::HEIGHT_W-1:0] height_reg;
    logic [ed565_pkg::COL_W-1:0]    col_reg;
    logic [ed565_pkg::COL_W-1:0]    col_next;
    logic [ed565_pkg::ROW_W-1:0]    row_reg;
    logic [ed565_pkg::ROW_W-1:0]    row_next;
    logic [ed565_pkg::WIDTH_W-1:0]  width_eff;
    logic [ed565_pkg::HEIGHT_W-1:0] height_eff;
    logic [ed565_pkg::WIDTH_W-1:0]  col_plus;
    logic [ed565_pkg::HEIGHT_W-1:0] row_plus;
    logic                           last_col;
    logic                           last_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ed565_pkg::WIDTH_W'(ed565_pkg::MAX_WIDTH);
            height_reg <= ed565_pkg::HEIGHT_W'(1024);
        end else if (cfg_wr_en) begin
            unique case (ed565_pkg::cfg_index_t'(cfg_index))
                ed565_pkg::REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_wdata[ed565_pkg::WIDTH_W-1:0];
                end
                ed565_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_wdata[ed565_pkg::HEIGHT_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            width_eff = ed565_pkg::WIDTH_W'(1);
        end else if (width_reg > ed565_pkg::WIDTH_W'(ed565_pkg::MAX_WIDTH)) begin
            width_eff = ed565_pkg::WIDTH_W'(ed565_pkg::MAX_WIDTH);
        end else begin
            width_eff = width_reg;
        end
        if (height_reg == '0) begin
            height_eff = ed565_pkg::HEIGHT_W'(1);
        end else if (height_reg > ed565_pkg::HEIGHT_W'(ed565_pkg::MAX_HEIGHT)) begin
            height_eff = ed565_pkg::HEIGHT_W'(ed565_pkg::MAX_HEIGHT);
        end else begin
            height_eff = height_reg;
        end
        col_plus = ed565_pkg::WIDTH_W'(col_reg) + ed565_pkg::WIDTH_W'(1);
        row_plus = ed565_pkg::HEIGHT_W'(row_reg) + ed565_pkg::HEIGHT_W'(1);
        last_col = (col_plus >= width_eff);
        last_row = (row_plus >= height_eff);
        col_next = last_col ? '0 : col_plus[ed565_pkg::COL_W-1:0];
        row_next = row_reg;
        if (last_col) begin
            row_next = last_row ? '0 : row_plus[ed565_pkg::ROW_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (advance) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign pos.col      = col_reg;
    assign pos.last_col = last_col;
    assign pos.last_row = last_row;

endmodule

`default_nettype wire

// ===== rtl/ed565_diffuse.sv =====
// ----------------------------------------------------------------------------
// ed565_diffuse
// Per-pixel quantization and error spreading, with the carried error, the
// next-row partial sums and the valid extent of the row memory.
// ----------------------------------------------------------------------------
`default_nettype none

module ed565_diffuse (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        fire,
    input  wire ed565_pkg::pos_t             pos,
    input  wire ed565_pkg::pix_vec_t         pix,
    input  wire ed565_pkg::err_vec_t         mem_q,
    output ed565_pkg::pix_vec_t              pix_out,
    output logic                             wr_en,
    output logic [ed565_pkg::COL_W-1:0]      wr_addr,
    output ed565_pkg::err_vec_t              wr_data
);

    ed565_pkg::err_vec_t           carry_reg;
    ed565_pkg::err_vec_t           carry_next;
    ed565_pkg::err_vec_t           acc_lo_reg;
    ed565_pkg::err_vec_t           acc_lo_next;
    ed565_pkg::err_vec_t           acc_hi_reg;
    ed565_pkg::err_vec_t           acc_hi_next;
    ed565_pkg::err_vec_t           tail_reg;
    logic [ed565_pkg::CNT_W-1:0]   fill_reg;
    logic [ed565_pkg::CNT_W-1:0]   fill_next;
    logic [ed565_pkg::CNT_W-1:0]   col_ext;
    logic [ed565_pkg::CNT_W-1:0]   col_plus;
    ed565_pkg::err_vec_t           cur_err;
    ed565_pkg::err_vec_t           fwd_err;

    // Entries below the fill count were written during the previous row; the
    // last of them is still held in the tail register.
    always_comb begin
        col_ext  = ed565_pkg::CNT_W'(pos.col);
        col_plus = col_ext + ed565_pkg::CNT_W'(1);
        if (col_ext >= fill_reg) begin
            cur_err = '0;
        end else if (col_plus == fill_reg) begin
            cur_err = tail_reg;
        end else begin
            cur_err = mem_q;
        end
    end

    always_comb begin
        ed565_pkg::chan_res_t res;
        ed565_pkg::err_t      d;
        for (int c = 0; c < ed565_pkg::NUM_CH; c++) begin
            res = ed565_pkg::dither_chan(pix[c], cur_err[c], carry_reg[c],
                                         (c == ed565_pkg::CH_GREEN));
            d = ed565_pkg::ext_diff(res.diff);
            pix_out[c]     = res.value;
            carry_next[c]  = pos.last_col ? '0 : ((d <<< 3) - d);
            wr_data[c]     = acc_lo_reg[c] + ((d <<< 1) + d);
            fwd_err[c]     = acc_hi_reg[c] + ((d <<< 2) + d);
            acc_hi_next[c] = pos.last_col ? '0 : d;
        end
        acc_lo_next = fwd_err;
        fill_next   = fill_reg;
        if (pos.last_col) begin
            fill_next = pos.last_row ? '0 : col_plus;
        end
        wr_en   = fire && (pos.col != '0);
        wr_addr = pos.col - ed565_pkg::COL_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg  <= '0;
            acc_hi_reg <= '0;
            fill_reg   <= '0;
        end else if (fire) begin
            carry_reg  <= carry_next;
            acc_hi_reg <= acc_hi_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            acc_lo_reg <= acc_lo_next;
            if (pos.last_col) begin
                tail_reg <= fwd_err;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/error_diffusion_rgb565_unit.sv =====
// ----------------------------------------------------------------------------
// error_diffusion_rgb565_unit
// Floyd-Steinberg dithering of raster-order RGB888 pixels to RGB565 levels.
// Throughput: one pixel per cycle when the result side does not stall; the
// left-neighbor error loop closes in the single compute stage between the
// input register and the output register, through which each result passes.
// Reset clears position, carried error and the row memory fill count; the row
// memory itself needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module error_diffusion_rgb565_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ed565_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ed565_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [7:0]                      s_red_in,
    input  wire logic [7:0]                      s_green_in,
    input  wire logic [7:0]                      s_blue_in,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [7:0]                           m_red_out,
    output logic [7:0]                           m_green_out,
    output logic [7:0]                           m_blue_out,
    output logic                                 m_image_done
);

    logic                          accept;
    logic                          fire;
    ed565_pkg::pos_t               pos;
    logic                          s1_valid_reg;
    ed565_pkg::pix_vec_t           s1_pix_reg;
    ed565_pkg::pos_t               s1_pos_reg;
    ed565_pkg::err_vec_t           mem_q;
    ed565_pkg::pix_vec_t           pix_out;
    logic                          wr_en;
    logic [ed565_pkg::COL_W-1:0]   wr_addr;
    ed565_pkg::err_vec_t           wr_data;
    logic                          m_valid_reg;
    ed565_pkg::pix_vec_t           m_pix_reg;
    logic                          m_done_reg;

    assign fire    = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || fire;
    assign accept  = s_valid && s_ready;

    ed565_position u_position (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (accept),
        .pos       (pos)
    );

    ed565_row_mem u_row_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (pos.col),
        .rd_data (mem_q)
    );

    ed565_diffuse u_diffuse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .pos     (s1_pos_reg),
        .pix     (s1_pix_reg),
        .mem_q   (mem_q),
        .pix_out (pix_out),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg[ed565_pkg::CH_RED]   <= s_red_in;
            s1_pix_reg[ed565_pkg::CH_GREEN] <= s_green_in;
            s1_pix_reg[ed565_pkg::CH_BLUE]  <= s_blue_in;
            s1_pos_reg                      <= pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_pix_reg  <= pix_out;
            m_done_reg <= s1_pos_reg.last_col && s1_pos_reg.last_row;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_red_out    = m_pix_reg[ed565_pkg::CH_RED];
    assign m_green_out  = m_pix_reg[ed565_pkg::CH_GREEN];
    assign m_blue_out   = m_pix_reg[ed565_pkg::CH_BLUE];
    assign m_image_done = m_done_reg;

endmodule

`default_nettype wire

// ===== sim/error_diffusion_rgb565_checker.sv =====
// ----------------------------------------------------------------------------
// error_diffusion_rgb565_checker
// Watches the register port and both channels of the RGB565 error diffusion
// unit, predicts every dithered pixel from the accepted input transactions,
// and compares each result transaction field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module error_diffusion_rgb565_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ed565_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ed565_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  wire logic [7:0]                      s_red_in,
    input  wire logic [7:0]                      s_green_in,
    input  wire logic [7:0]                      s_blue_in,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire logic [7:0]                      m_red_out,
    input  wire logic [7:0]                      m_green_out,
    input  wire logic [7:0]                      m_blue_out,
    input  wire logic                            m_image_done,
    output int                                   mismatch_count,
    output int                                   pending_count
);
    import ed565_pkg::*;

    typedef struct packed {
        pix_t red;
        pix_t green;
        pix_t blue;
        logic done;
    } dithered_pixel_t;

    logic [WIDTH_W-1:0]  width_cfg;
    logic [HEIGHT_W-1:0] height_cfg;

    // Errors are held in sixteenths of a code step.
    int row_err   [MAX_WIDTH][NUM_CH];
    int below_err [MAX_WIDTH][NUM_CH];
    int right_err [NUM_CH];
    int col_pos;
    int row_pos;

    dithered_pixel_t dithered_q[$];
    dithered_pixel_t want;
    pix_vec_t        pixel_in;

    function automatic void clear_error_stores();
        for (int i = 0; i < MAX_WIDTH; i++) begin
            for (int c = 0; c < NUM_CH; c++) begin
                row_err[i][c] = 0;
                below_err[i][c] = 0;
            end
        end
        for (int c = 0; c < NUM_CH; c++) begin
            right_err[c] = 0;
        end
    endfunction

    function automatic pix_t requantize(input int level, input int bits);
        int q;
        q = level >> (8 - bits);
        return pix_t'(((q << (8 - bits)) | (q >> (2 * bits - 8))) & 255);
    endfunction

    function automatic dithered_pixel_t diffuse_pixel(input pix_vec_t px);
        int              w;
        int              h;
        int              x;
        int              e16;
        int              level;
        int              d;
        logic            end_col;
        logic            end_row;
        pix_vec_t        outv;
        dithered_pixel_t res;
        w = int'(width_cfg);
        h = int'(height_cfg);
        if (w < 1) begin
            w = 1;
        end
        if (w > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end
        if (h < 1) begin
            h = 1;
        end
        if (h > MAX_HEIGHT) begin
            h = MAX_HEIGHT;
        end
        x = col_pos;
        end_col = (x + 1 >= w);
        end_row = (row_pos + 1 >= h);
        for (int c = 0; c < NUM_CH; c++) begin
            e16 = row_err[x][c] + right_err[c];
            e16 = e16 / 16;
            level = int'(px[c]) + e16;
            if (level < 0) begin
                level = 0;
            end
            if (level > 255) begin
                level = 255;
            end
            outv[c] = requantize(level, (c == CH_GREEN) ? 6 : 5);
            d = level - int'(outv[c]);
            right_err[c] = end_col ? 0 : 7 * d;
            if (x > 0) begin
                below_err[x - 1][c] += 3 * d;
            end
            below_err[x][c] += 5 * d;
            if (!end_col) begin
                below_err[x + 1][c] += d;
            end
        end
        res.red = outv[CH_RED];
        res.green = outv[CH_GREEN];
        res.blue = outv[CH_BLUE];
        res.done = end_col && end_row;
        if (!end_col) begin
            col_pos = x + 1;
        end else begin
            col_pos = 0;
            if (end_row) begin
                clear_error_stores();
                row_pos = 0;
            end else begin
                for (int i = 0; i < MAX_WIDTH; i++) begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        row_err[i][c] = below_err[i][c];
                        below_err[i][c] = 0;
                    end
                end
                for (int c = 0; c < NUM_CH; c++) begin
                    right_err[c] = 0;
                end
                row_pos = row_pos + 1;
            end
        end
        return res;
    endfunction

    task automatic note_mismatch(input string what, input dithered_pixel_t exp_px);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] %s: expected r=%0d g=%0d b=%0d done=%0b", $realtime, what,
                     exp_px.red, exp_px.green, exp_px.blue, exp_px.done);
            $display("    actual r=%0d g=%0d b=%0d done=%0b",
                     m_red_out, m_green_out, m_blue_out, m_image_done);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg = WIDTH_W'(1024);
            height_cfg = HEIGHT_W'(1024);
            clear_error_stores();
            col_pos = 0;
            row_pos = 0;
            dithered_q.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_IMAGE_WIDTH) begin
                    width_cfg = cfg_wdata[WIDTH_W-1:0];
                end else if (cfg_index == REG_IMAGE_HEIGHT) begin
                    height_cfg = cfg_wdata[HEIGHT_W-1:0];
                end
            end
            if (s_valid && s_ready) begin
                pixel_in[CH_RED] = s_red_in;
                pixel_in[CH_GREEN] = s_green_in;
                pixel_in[CH_BLUE] = s_blue_in;
                dithered_q.push_back(diffuse_pixel(pixel_in));
            end
            if (m_valid && m_ready) begin
                if (dithered_q.size() == 0) begin
                    note_mismatch("result transaction with nothing expected", '0);
                end else begin
                    want = dithered_q.pop_front();
                    if (m_red_out !== want.red || m_green_out !== want.green ||
                        m_blue_out !== want.blue || m_image_done !== want.done) begin
                        note_mismatch("result transaction differs", want);
                    end
                end
            end
        end
        pending_count = dithered_q.size();
    end

endmodule

// ===== sim/error_diffusion_rgb565_unit_tb.sv =====
// ----------------------------------------------------------------------------
// error_diffusion_rgb565_unit_tb
// Drives the RGB565 error diffusion unit with directed corner pixels and
// register settings, then with shaded random images of many sizes, while both
// channels idle at random and the result side stalls for long stretches.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module error_diffusion_rgb565_unit_tb;
    import ed565_pkg::*;

    localparam int IDLE_PCT       = 18;
    localparam int RANDOM_PIXELS  = 500;
    localparam int STALL_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_wdata   = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    pix_t                 s_red_in    = '0;
    pix_t                 s_green_in  = '0;
    pix_t                 s_blue_in   = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    pix_t                 m_red_out;
    pix_t                 m_green_out;
    pix_t                 m_blue_out;
    logic                 m_image_done;

    int mismatch_count;
    int pending_count;
    bit no_idle       = 1'b0;
    bit sender_busy   = 1'b0;
    int results_taken = 0;
    int stall_left    = 0;
    int next_stall_at = 300;
    int idle_cycles   = 0;

    error_diffusion_rgb565_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_image_done (m_image_done)
    );

    error_diffusion_rgb565_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red_in       (s_red_in),
        .s_green_in     (s_green_in),
        .s_blue_in      (s_blue_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red_out      (m_red_out),
        .m_green_out    (m_green_out),
        .m_blue_out     (m_blue_out),
        .m_image_done   (m_image_done),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        sender_busy = s_valid;
        if (m_valid && m_ready) begin
            results_taken++;
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // The result side occasionally refuses transactions for a long stretch so
    // that the unit fills up and pushes back on the pixel input.
    always @(negedge aclk) begin
        if (stall_left == 0 && sender_busy && results_taken >= next_stall_at) begin
            stall_left = STALL_CYCLES;
            next_stall_at = next_stall_at + 4000;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready = 1'b0;
        end else begin
            m_ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic pix_t shade(input pix_t base);
        int v;
        case ($urandom_range(3))
            0: begin
                return pix_t'($urandom_range(255));
            end
            1: begin
                if ($urandom_range(1) == 1) begin
                    return pix_t'($urandom_range(3));
                end
                return pix_t'(252 + $urandom_range(3));
            end
            default: begin
                v = int'(base) + int'($urandom_range(6)) - 3;
                if (v < 0) begin
                    v = 0;
                end
                if (v > 255) begin
                    v = 255;
                end
                return pix_t'(v);
            end
        endcase
    endfunction

    task automatic send_pixel(input pix_t red, input pix_t green, input pix_t blue);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_red_in = red;
        s_green_in = green;
        s_blue_in = blue;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic send_shaded(input int count, input pix_vec_t base);
        for (int i = 0; i < count; i++) begin
            send_pixel(shade(base[CH_RED]), shade(base[CH_GREEN]), shade(base[CH_BLUE]));
        end
    endtask

    // Every pixel yields exactly one result, so an empty
    // expectation store means the unit is idle.
    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending_count != 0) begin
            @(negedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic configure(input int width, input int height);
        cfg_index = REG_IMAGE_WIDTH;
        cfg_wdata = CFG_W'(width);
        cfg_wr_en = 1'b1;
        @(negedge aclk);
        cfg_index = REG_IMAGE_HEIGHT;
        cfg_wdata = CFG_W'(height);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    initial begin : stimulus
        pix_vec_t base;
        int       w;
        int       h;
        int       w_eff;
        int       h_eff;
        int       burst;
        int       random_sent;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset settings, then shrinking both registers mid-row ends the image.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd7, 8'd3, 8'd7);
        send_pixel(8'd0, 8'd0, 8'd0);
        wait_drained();
        configure(0, 0);
        send_pixel(8'd128, 8'd64, 8'd200);

        // Clamping at both ends of the range in a small image.
        wait_drained();
        configure(3, 2);
        send_pixel(8'd7, 8'd3, 8'd7);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd252, 8'd254, 8'd252);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd5, 8'd1, 8'd4);

        // Oversized registers, then a narrower width and a lower height.
        wait_drained();
        configure(2047, 8191);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd1, 8'd2, 8'd3);
        send_pixel(8'd254, 8'd253, 8'd252);
        wait_drained();
        configure(2, 8191);
        send_pixel(8'd100, 8'd150, 8'd200);
        wait_drained();
        configure(2, 1);
        send_pixel(8'd9, 8'd10, 8'd11);
        send_pixel(8'd250, 8'd251, 8'd249);

        // A long stretch of a full-width row with no idling on either side.
        wait_drained();
        configure(1024, 2);
        base = pix_vec_t'($urandom);
        no_idle = 1'b1;
        send_shaded(160, base);
        no_idle = 1'b0;

        // One-pixel rows under an oversized height.
        wait_drained();
        configure(1, 8191);
        base = pix_vec_t'($urandom);
        send_shaded(64, base);

        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            case ($urandom_range(9))
                0: begin
                    case ($urandom_range(3))
                        0: w = 0;
                        1: w = 1024;
                        2: w = 2047;
                        default: w = $urandom_range(2047, 1025);
                    endcase
                end
                1, 2: w = $urandom_range(64, 13);
                default: w = $urandom_range(12, 1);
            endcase
            case ($urandom_range(9))
                0: h = 0;
                1: h = ($urandom_range(1) == 1) ? 8191 : $urandom_range(8191, 4097);
                2: h = $urandom_range(40, 6);
                default: h = $urandom_range(5, 1);
            endcase
            w_eff = (w < 1) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
            h_eff = (h < 1) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
            if ($urandom_range(9) < 3 || w_eff * h_eff > 120) begin
                burst = $urandom_range(40, 1);
            end else begin
                burst = w_eff * h_eff * $urandom_range(2, 1);
            end
            wait_drained();
            configure(w, h);
            base = pix_vec_t'($urandom);
            no_idle = (random_sent >= 300 && random_sent < 420);
            send_shaded(burst, base);
            random_sent = random_sent + burst;
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (4) @(negedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
